FILE: rtl/core/csu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the cosine similarity unit
// no dependencies
package csu_pkg;

    localparam int ElemW     = 16;
    localparam int SumW      = 48;
    localparam int ProdW     = 96;
    localparam int RhsW      = ProdW + 30;
    localparam int WideW     = 130;
    localparam int QW        = 15;
    localparam int StepW     = 6;
    localparam int MaxVecLen = 65536;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_CHECK,
        ST_MUL_P,
        ST_MUL_R,
        ST_SEARCH,
        ST_EMIT
    } csu_state_t;

    typedef enum logic {
        SEL_P,
        SEL_R
    } csu_sel_t;

    typedef struct packed {
        logic     take;
        logic     mul_init;
        csu_sel_t mul_sel;
        logic     mul_step;
        logic     srch_init;
        logic     srch_step;
        logic     emit;
    } csu_cmd_t;

    typedef struct packed {
        logic last_hit;
        logic degen;
        logic mul_last;
        logic srch_last;
        logic out_busy;
    } csu_status_t;

endpackage

FILE: rtl/core/cosine_similarity_unit.sv
`timescale 1ns / 1ps
// top level of the cosine similarity unit: controller plus datapath
// depends on csu_pkg, csu_ctrl, csu_datapath
//
// channel  dir  tdata                               tuser / tlast
// s_       in   [15:0] a_value, [31:16] b_value     tlast last_element
// m_       out  [15:0] similarity                   tuser[0] degenerate
//
// one element pair per cycle while accumulating
// after a closing pair s_tready stays low through one check, two 48-step shift-add
// multiplies, a 15-step ratio search and one emit; a zero norm goes from check to emit
// a waiting result does not stop accumulation, but holds the emit of the next one
// reset clears the sums, the count and the output valid
module cosine_similarity_unit import csu_pkg::*; #(
    parameter int MAX_VECTOR_LENGTH = MaxVecLen
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // a_value, b_value
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // similarity
    output logic [0:0]  m_tuser    // degenerate
);

    csu_cmd_t           cmd;
    csu_status_t        status;
    logic signed [15:0] sim;
    logic               degen;

    csu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csu_datapath #(
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .a_value      (s_tdata[15:0]),
        .b_value      (s_tdata[31:16]),
        .last_element (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .similarity   (sim),
        .degenerate   (degen)
    );

    assign m_tdata    = sim;
    assign m_tuser[0] = degen;

endmodule

FILE: rtl/core/csu_ctrl.sv
`timescale 1ns / 1ps
// controller of the cosine similarity unit: sequences accumulate, multiply and search
// depends on csu_pkg
module csu_ctrl import csu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  csu_status_t status,
    output csu_cmd_t    cmd
);

    csu_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_ACC: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && status.last_hit) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.degen) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.mul_init = 1'b1;
                    cmd.mul_sel  = SEL_P;
                    state_next   = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = SEL_P;
                if (status.mul_last) begin
                    cmd.mul_init = 1'b1;
                    cmd.mul_sel  = SEL_R;
                    state_next   = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = SEL_R;
                if (status.mul_last) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.srch_step = 1'b1;
                if (status.srch_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
        cmd.srch_init = (state_reg == ST_MUL_R) && status.mul_last;
    end

endmodule

FILE: rtl/core/csu_datapath.sv
`timescale 1ns / 1ps
// datapath of the cosine similarity unit: sums, shift-add multiplier, bitwise ratio search
// depends on csu_pkg
module csu_datapath import csu_pkg::*; #(
    parameter int MAX_VECTOR_LENGTH = MaxVecLen
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic signed [ElemW-1:0] a_value,
    input  logic signed [ElemW-1:0] b_value,
    input  logic                    last_element,
    input  csu_cmd_t                cmd,
    output csu_status_t             status,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic signed [ElemW-1:0] similarity,
    output logic                    degenerate
);

    localparam int CntW = $clog2(MAX_VECTOR_LENGTH + 1);
    localparam int OpW  = SumW;
    localparam logic signed [SumW:0] SumMax = {2'b00, {(SumW - 1){1'b1}}};
    localparam logic signed [SumW:0] SumMin = {2'b11, {(SumW - 1){1'b0}}};

    logic signed [SumW-1:0] dot_sum_reg, na_sum_reg, nb_sum_reg;
    logic signed [SumW-1:0] dot_sum_next, na_sum_next, nb_sum_next;
    logic [CntW-1:0]        count_reg;

    logic signed [SumW-1:0] dot_reg, na_reg, nb_reg;
    logic [ProdW-1:0]       mx_reg, macc_reg, p_reg;
    logic [OpW-1:0]         my_reg;
    logic [RhsW-1:0]        r_reg;
    csu_sel_t               sel_reg;
    logic [StepW-1:0]       cnt_reg;
    logic signed [WideW-1:0] s_reg, t_reg;
    logic [QW-1:0]          q_reg;

    logic                    m_tvalid_reg;
    logic signed [ElemW-1:0] sim_reg;
    logic                    degen_reg;

    function automatic logic signed [SumW-1:0] sat_add(
        input logic signed [SumW-1:0]    s,
        input logic signed [2*ElemW-1:0] p
    );
        logic signed [SumW:0] r;
        r = $signed({s[SumW-1], s}) + (SumW + 1)'(p);
        if (r > SumMax) begin
            return SumMax[SumW-1:0];
        end else if (r < SumMin) begin
            return SumMin[SumW-1:0];
        end
        return r[SumW-1:0];
    endfunction

    logic signed [2*ElemW-1:0] p_ab, p_aa, p_bb;
    logic [OpW-1:0]            mag;
    logic [ProdW-1:0]          macc_sum;
    logic [3:0]                bit_j;
    logic [5:0]                sh_t, sh_p, sh_u;
    logic signed [WideW-1:0]   p_wide, cand;
    logic                      take_bit;
    logic [QW:0]               q_ext;

    always_comb begin
        p_ab = a_value * b_value;
        p_aa = a_value * a_value;
        p_bb = b_value * b_value;
        dot_sum_next = sat_add(dot_sum_reg, p_ab);
        na_sum_next  = sat_add(na_sum_reg, p_aa);
        nb_sum_next  = sat_add(nb_sum_reg, p_bb);

        mag      = dot_reg[SumW-1] ? OpW'(-dot_reg) : OpW'(dot_reg);
        macc_sum = my_reg[0] ? macc_reg + mx_reg : macc_reg;

        bit_j    = 4'(QW - 1) - cnt_reg[3:0];
        sh_t     = {2'b00, bit_j} + 6'd2;
        sh_u     = {2'b00, bit_j} + 6'd1;
        sh_p     = {1'b0, bit_j, 1'b0} + 6'd2;
        p_wide   = $signed({{(WideW - ProdW){1'b0}}, p_reg});
        cand     = s_reg + (t_reg <<< sh_t) + (p_wide <<< sh_p);
        take_bit = !q_reg[QW-1] && (cand <= $signed({{(WideW - RhsW){1'b0}}, r_reg}));
        q_ext    = {1'b0, q_reg};

        status.last_hit  = last_element || (count_reg == CntW'(MAX_VECTOR_LENGTH - 1));
        status.degen     = (na_reg == '0) || (nb_reg == '0);
        status.mul_last  = (cnt_reg == StepW'(OpW - 1));
        status.srch_last = (cnt_reg == StepW'(QW - 1));
        status.out_busy  = m_tvalid_reg && !m_tready;
    end

    // running sums and element count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_sum_reg <= '0;
            na_sum_reg  <= '0;
            nb_sum_reg  <= '0;
            count_reg   <= '0;
        end else if (cmd.take) begin
            if (status.last_hit) begin
                dot_sum_reg <= '0;
                na_sum_reg  <= '0;
                nb_sum_reg  <= '0;
                count_reg   <= '0;
            end else begin
                dot_sum_reg <= dot_sum_next;
                na_sum_reg  <= na_sum_next;
                nb_sum_reg  <= nb_sum_next;
                count_reg   <= count_reg + 1'b1;
            end
        end
    end

    // snapshot, multiplier, search and result registers
    always_ff @(posedge aclk) begin
        if (cmd.take && status.last_hit) begin
            dot_reg <= dot_sum_next;
            na_reg  <= na_sum_next;
            nb_reg  <= nb_sum_next;
        end
        if (cmd.mul_init) begin
            sel_reg  <= cmd.mul_sel;
            macc_reg <= '0;
            if (cmd.mul_sel == SEL_P) begin
                mx_reg <= ProdW'(unsigned'(na_reg));
                my_reg <= OpW'(unsigned'(nb_reg));
            end else begin
                mx_reg <= ProdW'(mag);
                my_reg <= mag;
            end
        end else if (cmd.mul_step) begin
            macc_reg <= macc_sum;
            mx_reg   <= mx_reg << 1;
            my_reg   <= my_reg >> 1;
        end
        if (cmd.mul_step && status.mul_last) begin
            if (sel_reg == SEL_P) begin
                p_reg <= macc_sum;
            end else begin
                r_reg <= {macc_sum, 30'b0};
            end
        end
        if (cmd.mul_init || cmd.srch_init) begin
            cnt_reg <= '0;
        end else if (cmd.mul_step || cmd.srch_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.srch_init) begin
            s_reg <= p_wide;
            t_reg <= -p_wide;
            q_reg <= '0;
        end else if (cmd.srch_step && take_bit) begin
            s_reg <= cand;
            t_reg <= t_reg + (p_wide <<< sh_u);
            q_reg <= q_reg | (QW'(1) << bit_j);
        end
        if (cmd.emit) begin
            if (status.degen) begin
                sim_reg   <= '0;
                degen_reg <= 1'b1;
            end else begin
                sim_reg   <= dot_reg[SumW-1] ? ElemW'(-q_ext) : ElemW'(q_ext);
                degen_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign similarity = sim_reg;
    assign degenerate = degen_reg;

endmodule

FILE: rtl/core/csu_checker.sv
`timescale 1ns / 1ps
// port-level checks for the cosine similarity unit, bound to the top level
// depends on cosine_similarity_unit
module csu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("degenerate result not zero");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd16384) && ($signed(m_tdata) >= -16'sd16384))
        else $error("similarity out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/cosine_similarity_unit_test.sv
`timescale 1ns / 1ps
// testbench for cosine_similarity_unit: drives element pairs, predicts similarity per vector
// depends on csu_pkg and cosine_similarity_unit
module cosine_similarity_unit_test import csu_pkg::*;;

    localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic signed [15:0] sim;
        logic               degen;
    } cos_result_t;

    class cosine_scoreboard;
        logic signed [47:0] dot_acc, na_acc, nb_acc;
        int unsigned pair_count;
        cos_result_t pending[$];
        int errors;

        function new();
            dot_acc = 0; na_acc = 0; nb_acc = 0; pair_count = 0; errors = 0;
        endfunction

        function logic signed [47:0] sat_sum(logic signed [47:0] s, logic signed [47:0] p);
            logic signed [48:0] r;
            r = {s[47], s} + {p[47], p};
            if (r > 49'sd140737488355327) return SumMax;
            if (r < -49'sd140737488355328) return SumMin;
            return r[47:0];
        endfunction

        // largest q up to 16384 with (2q-1)^2 * na * nb <= mag^2 * 2^30
        function logic [15:0] ratio_q14(logic [47:0] mag, logic [47:0] na, logic [47:0] nb);
            logic [95:0] prod;
            logic [159:0] rhs, lhs;
            int unsigned lo, hi, mid;
            logic [31:0] k;
            prod = na * nb;
            rhs = ({112'd0, mag} * {112'd0, mag}) << 30;
            lo = 0; hi = 16384;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                k = 2 * mid - 1;
                lhs = {64'd0, prod} * {128'd0, k * k};
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo[15:0];
        endfunction

        function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
            cos_result_t r;
            logic signed [47:0] dv;
            logic [47:0] mag;
            logic [15:0] q;
            dot_acc = sat_sum(dot_acc, 48'(a * b));
            na_acc = sat_sum(na_acc, 48'(a * a));
            nb_acc = sat_sum(nb_acc, 48'(b * b));
            pair_count++;
            if (pair_count >= MaxVecLen) last = 1'b1;
            if (!last) return;
            if (na_acc == 0 || nb_acc == 0) begin
                r.sim = 0; r.degen = 1'b1;
            end else begin
                dv = dot_acc;
                mag = dv < 0 ? -dv : dv;
                q = ratio_q14(mag, na_acc, nb_acc);
                r.sim = dv < 0 ? -q : q;
                r.degen = 1'b0;
            end
            pending.push_back(r);
            dot_acc = 0; na_acc = 0; nb_acc = 0; pair_count = 0;
        endfunction

        function void check_result(logic [15:0] sim, logic degen);
            cos_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result sim=%0d degen=%0d", $time, $signed(sim), degen);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.sim !== sim)
                $display("%0t: similarity expected %0d actual %0d", $time, e.sim, $signed(sim));
            if (e.degen !== degen)
                $display("%0t: degenerate expected %0d actual %0d", $time, e.degen, degen);
            if (e.sim !== sim || e.degen !== degen) errors++;
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0] m_tuser;

    cosine_scoreboard board;
    bit quiet_phase = 0;
    bit long_hold = 0;
    int idle_cycles = 0;

    cosine_similarity_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_pair(s_tdata[15:0], s_tdata[31:16], s_tlast);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchLimit) begin
                $display("cosine_similarity_unit test failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, long hold-offs while the sender asks for them
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(negedge aclk);
                long_hold = 0;
            end
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
        int n;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge aclk);
        end
        s_tdata <= {b, a};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 2047)) - 1024);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'd0;
        endcase
    endfunction

    task automatic send_vector(input int len);
        int i, ma, mb;
        ma = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : $urandom_range(2, 3));
        mb = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : $urandom_range(2, 3));
        for (i = 0; i < len; i++) send_pair(rand_elem(ma), rand_elem(mb), i == len - 1);
    endtask

    initial begin
        int sent, len, i;
        board = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, zero norms, opposite and parallel vectors
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h0000, 16'h1234, 1'b1);
        send_pair(16'h0400, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0400, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0400, 1'b1);
        send_pair(16'h0400, 16'hFC00, 1'b0);
        send_pair(16'hFC00, 16'h0400, 1'b1);
        send_pair(16'h0001, 16'hFFFF, 1'b1);
        send_pair(16'h0003, 16'h0004, 1'b0);
        send_pair(16'h0004, 16'hFFFD, 1'b1);
        // ten pairs of the most negative element in one vector
        for (i = 0; i < 10; i++) send_pair(16'h8000, 16'h8000, i == 9);

        // random vectors, with long receiver hold-offs asked for while sent is between 400 and 460
        sent = 23;
        while (sent < 1300) begin
            if (sent > 400 && sent < 460) long_hold = 1;
            if (sent > 1150) quiet_phase = 1;
            len = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
            send_vector(len);
            sent += len;
        end
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (board.errors == 0) begin
            $display("cosine_similarity_unit test passed");
        end else begin
            $display("cosine_similarity_unit test failed");
        end
        $finish;
    end
endmodule
